// ===== rtl/tcw_pkg.sv =====
// Package for the text console writer: field widths, defaults and command codes.
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = ATTR_W + CHAR_W;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [CHAR_W-1:0] NL_CHAR    = 8'h0A;

	localparam logic [1:0] KIND_PUT = 2'd0;
	localparam logic [1:0] KIND_BS  = 2'd1;
	localparam logic [1:0] KIND_CLR = 2'd2;
	localparam logic [1:0] KIND_QRY = 2'd3;

endpackage

// ===== rtl/text_console_writer.sv =====
// Text console writer: cursor sequencer over a ROWS x COLUMNS store of 16-bit cells.
//
//  channel  | signals                          | beat contents
//  ---------+----------------------------------+-------------------------------------------
//  command  | s_tvalid s_tready s_tdata s_tuser| tuser: kind; tdata: char, query row/col
//  result   | m_tvalid m_tready m_tdata        | cursor, attribute read, out of range, scroll
//  config   | cfg_valid cfg_ready cfg_data     | text attribute for written cells
//
// Put-char, newline, backspace and read-attribute do their write or registered read on
// the memory port (write or read side) as the command is taken, then load the result.
// Clear blanks the store one cell per cycle on the write port, then loads the result.
// In a scroll the row copy streams read/write one
// cell per cycle, then the bottom row is blanked one cell per cycle.
// Reset clears the cursor and sets the attribute to 0x0F; the store is not cleared.
// A result waiting in the output register holds the next command at its end.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], query_row[12:8], query_col[19:13], zero pad
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // cur_row[4:0], cur_col[11:5], attr_read[19:12],
	                               // out_of_range[20], scrolled[21], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // text_attribute
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0] COPY_N    = AW'(CELLS - COLUMNS);  // first cell of bottom row
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

	// sequencer states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCROLL = 2'd1;
	localparam logic [1:0] ST_FILL   = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]        state_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ATTR_W-1:0] attr_q;
	logic [AW-1:0]     cnt_q;
	logic              pend_q;
	logic [AW-1:0]     pend_addr_q;
	logic              scr_q;
	logic              oor_q;
	logic              qry_q;
	logic              m_tvalid_q;
	logic [23:0]       m_tdata_q;
	logic [CELL_W-1:0] rd_q;

	logic [CELL_W-1:0] mem [CELLS];

	// command fields
	logic [1:0]        kind;
	logic [CHAR_W-1:0] char_code;
	logic [ROW_W-1:0]  query_row;
	logic [COL_W-1:0]  query_col;

	assign kind      = s_tuser;
	assign char_code = s_tdata[7:0];
	assign query_row = s_tdata[12:8];
	assign query_col = s_tdata[19:13];

	logic              accept;
	logic [AW-1:0]     cur_addr;
	logic [AW-1:0]     q_addr;
	logic              q_oor;
	logic [COL_W:0]    col_inc;
	logic [ROW_W:0]    row_inc;
	logic              wrap;
	logic              last_row;
	logic              at_origin;
	logic              is_nl;
	logic [CELL_W-1:0] blank;
	logic              load_out;

	// memory port controls
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign cur_addr  = AW'(row_q) * COLS_A + AW'(col_q);
	assign q_addr    = AW'(query_row) * COLS_A + AW'(query_col);
	assign q_oor     = ({1'b0, query_row} >= (ROW_W + 1)'(ROWS))
	                || ({1'b0, query_col} >= (COL_W + 1)'(COLUMNS));
	assign col_inc   = {1'b0, col_q} + (COL_W + 1)'(1);
	assign row_inc   = {1'b0, row_q} + (ROW_W + 1)'(1);
	assign wrap      = col_inc >= (COL_W + 1)'(COLUMNS);
	assign last_row  = row_inc >= (ROW_W + 1)'(ROWS);
	assign at_origin = (row_q == '0) && (col_q == '0);
	assign is_nl     = (char_code == NL_CHAR);
	assign blank     = {attr_q, BLANK_CHAR};
	assign load_out  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		we    = 1'b0;
		waddr = cur_addr;
		wdata = {attr_q, char_code};
		re    = 1'b0;
		raddr = q_addr;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_PUT: we = !is_nl;
						KIND_BS: begin
							// previous cell in row-major order, also across a row edge
							we    = !at_origin;
							waddr = cur_addr - AW'(1);
							wdata = blank;
						end
						KIND_QRY: re = !q_oor;
						default: ;
					endcase
				end
			end
			ST_SCROLL: begin
				// read one row down, write back the cell read in the cycle before
				re    = (cnt_q < COPY_N);
				raddr = cnt_q + COLS_A;
				we    = pend_q;
				waddr = pend_addr_q;
				wdata = rd_q;
			end
			ST_FILL: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = blank;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			row_q      <= '0;
			col_q      <= '0;
			attr_q     <= ATTR_RESET;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			scr_q      <= 1'b0;
			oor_q      <= 1'b0;
			qry_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			// a new result may replace the one leaving in the same cycle
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scr_q <= (kind == KIND_PUT) && (is_nl || wrap) && last_row;
						oor_q <= (kind == KIND_QRY) && q_oor;
						qry_q <= (kind == KIND_QRY) && !q_oor;
						case (kind)
							KIND_PUT: begin
								if (is_nl || wrap) begin
									col_q <= '0;
									if (last_row) begin
										// cursor stays on the bottom row
										cnt_q   <= '0;
										pend_q  <= 1'b0;
										state_q <= ST_SCROLL;
									end else begin
										row_q   <= row_inc[ROW_W-1:0];
										state_q <= ST_DONE;
									end
								end else begin
									col_q   <= col_inc[COL_W-1:0];
									state_q <= ST_DONE;
								end
							end
							KIND_BS: begin
								if (!at_origin) begin
									if (col_q != '0) begin
										col_q <= col_q - COL_W'(1);
									end else begin
										row_q <= row_q - ROW_W'(1);
										col_q <= COL_W'(COLUMNS - 1);
									end
								end
								state_q <= ST_DONE;
							end
							KIND_CLR: begin
								row_q   <= '0;
								col_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCROLL: begin
					pend_q      <= re;
					pend_addr_q <= cnt_q;
					if (cnt_q == COPY_N) begin
						// last copy drains now; the bottom row starts at this same index
						state_q <= ST_FILL;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_FILL: begin
					if (cnt_q == LAST_CELL) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				default: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {2'b00, scr_q, oor_q, (qry_q ? rd_q[CELL_W-1:CHAR_W] : 8'h00),
			              col_q, row_q};
		end
	end

`ifndef NO_ASSERTIONS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, row_q} < (ROW_W + 1)'(ROWS)) && ({1'b0, col_q} < (COL_W + 1)'(COLUMNS)))
		else $error("cursor off screen");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[21]) |-> (m_tdata[4:0] == ROW_W'(ROWS - 1)))
		else $error("scroll result not on bottom row");

	a_oor_attr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[20]) |-> (m_tdata[19:12] == 8'h00))
		else $error("out of range query returned an attribute");

	a_clear_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind == KIND_CLR)) |=> ((state_q == ST_FILL) && (cnt_q == '0)
		&& (row_q == '0) && (col_q == '0)))
		else $error("clear did not start the fill sweep");

	a_scroll_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCROLL) && we) |-> (waddr < COPY_N))
		else $error("row copy wrote into the bottom row");
`endif

endmodule
